/* hw/rtl/xbi_pkg.sv */
`timescale 1ns / 1ps

package xbi_pkg;

  localparam int VALUE_W = 64;
  localparam int RANK_W  = 7;

  // opcode codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

endpackage

/* hw/rtl/xbi_if.sv */
`timescale 1ns / 1ps

interface xbi_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [xbi_pkg::VALUE_W-1:0] value;

  modport source (output valid, opcode, value, input ready);
  modport sink   (input valid, opcode, value, output ready);
endinterface

interface xbi_out_if;
  logic                      valid;
  logic                      ready;
  logic                      independent;
  logic [xbi_pkg::RANK_W-1:0] rank;

  modport source (output valid, independent, rank, input ready);
  modport sink   (input valid, independent, rank, output ready);
endinterface

/* hw/rtl/xor_basis_insert.sv */
`timescale 1ns / 1ps

// Channel  Dir  Payload                         Item accepted when
// -------  ---  ------------------------------  -----------------------
// cmd      in   opcode, value[63:0]             cmd.valid & cmd.ready
// rsp      out  independent, rank[6:0]          rsp.valid & rsp.ready
//
// Insert item: a first step issues the top row read, then the rows are walked
// one per cycle, top bit down, from a memory with one write and one registered
// read port; then a commit step in S_DONE registers the result. The next item
// is taken only once the result is registered and the block is idle again.
// Clear item: goes straight to the commit step with no walk; all row valid
// bits drop at once, no sweep.
// Reset (rst, synchronous) empties the store and sets rank to zero at once.
// cmd.ready is high only while idle; a held result stalls the commit cycle.

module xor_basis_insert #(
  parameter int VEC_BITS = 64
) (
  input logic         clk,
  input logic         rst,
  xbi_in_if.sink      cmd,
  xbi_out_if.source   rsp
);

  localparam int IDX_W = $clog2(VEC_BITS);
  localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(VEC_BITS - 1);

  // control
  xbi_pkg::state_t state;
  xbi_pkg::state_t state_next;

  // item being worked on
  logic                      op;
  logic [VEC_BITS-1:0]       vec;      // running remainder
  logic                      iss;      // read addresses still being issued
  logic [IDX_W-1:0]          iss_idx;  // row address being read
  logic                      proc_vld; // rd_data holds row proc_idx
  logic [IDX_W-1:0]          proc_idx;
  logic                      found;    // remainder has a free leading bit
  logic [IDX_W-1:0]          top_idx;

  // basis store: row k has its leading bit at k; empty rows marked invalid
  logic [VEC_BITS-1:0]       mem [VEC_BITS];
  logic [VEC_BITS-1:0]       rd_data;
  logic [VEC_BITS-1:0]       row_vld;
  logic [xbi_pkg::RANK_W-1:0] rank;

  // result register
  logic                       rsp_vld;
  logic                       rsp_indep;
  logic [xbi_pkg::RANK_W-1:0] rsp_rank;

  logic                accept;
  logic                out_free;
  logic                commit;
  logic                last;
  logic                hit;
  logic                free;
  logic [VEC_BITS-1:0] vec_red;

  assign accept   = cmd.valid && cmd.ready;
  assign out_free = !rsp_vld || rsp.ready;
  assign last     = proc_vld && (proc_idx == '0);

  // Reduction step on the row that just came out of the memory. Rows below
  // proc_idx cannot touch bit proc_idx, so once this row is handled the bit
  // is final: a set bit over an empty row is the remainder's leading bit.
  assign hit     = vec[proc_idx] && row_vld[proc_idx];
  assign free    = vec[proc_idx] && !row_vld[proc_idx];
  assign vec_red = hit ? (vec ^ rd_data) : vec;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      xbi_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (cmd.opcode == xbi_pkg::OP_CLEAR) ? xbi_pkg::S_DONE
                                                         : xbi_pkg::S_RUN;
        end
      end
      xbi_pkg::S_RUN: begin
        if (last) state_next = xbi_pkg::S_DONE;
      end
      xbi_pkg::S_DONE: begin
        if (out_free) state_next = xbi_pkg::S_IDLE;
      end
      default: state_next = xbi_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.ready = 1'b0;
    commit    = 1'b0;
    case (state)
      xbi_pkg::S_IDLE: cmd.ready = 1'b1;
      xbi_pkg::S_RUN:  cmd.ready = 1'b0;
      xbi_pkg::S_DONE: commit    = out_free;
      default: begin
        cmd.ready = 1'b0;
        commit    = 1'b0;
      end
    endcase
  end

  assign rsp.valid       = rsp_vld;
  assign rsp.independent = rsp_indep;
  assign rsp.rank        = rsp_rank;

  // control and bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= xbi_pkg::S_IDLE;
      iss      <= 1'b0;
      proc_vld <= 1'b0;
      found    <= 1'b0;
      row_vld  <= '0;
      rank     <= '0;
      rsp_vld  <= 1'b0;
    end else begin
      state <= state_next;

      if (accept) begin
        iss      <= (cmd.opcode == xbi_pkg::OP_INSERT);
        proc_vld <= 1'b0;
        found    <= 1'b0;
      end else if (state == xbi_pkg::S_RUN) begin
        proc_vld <= iss;
        if (iss && (iss_idx == '0)) iss <= 1'b0;
        if (proc_vld && free && !found) found <= 1'b1;
      end

      if (commit) begin
        rsp_vld <= 1'b1;
        if (op == xbi_pkg::OP_CLEAR) begin
          row_vld <= '0;
          rank    <= '0;
        end else if (found) begin
          row_vld[top_idx] <= 1'b1;
          rank             <= rank + xbi_pkg::RANK_W'(1);
        end
      end else if (rsp.ready) begin
        rsp_vld <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= cmd.opcode;
      vec     <= cmd.value[VEC_BITS-1:0];  // bits above VEC_BITS ignored
      iss_idx <= TOP_IDX;
    end else if (state == xbi_pkg::S_RUN) begin
      proc_idx <= iss_idx;
      if (iss && (iss_idx != '0)) iss_idx <= iss_idx - IDX_W'(1);
      if (proc_vld) begin
        vec <= vec_red;
        if (free && !found) top_idx <= proc_idx;
      end
    end

    if (commit) begin
      if (op == xbi_pkg::OP_CLEAR) begin
        rsp_indep <= 1'b0;
        rsp_rank  <= '0;
      end else begin
        rsp_indep <= found;
        rsp_rank  <= found ? (rank + xbi_pkg::RANK_W'(1)) : rank;
      end
    end
  end

  // row memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (commit && (op == xbi_pkg::OP_INSERT) && found) begin
      mem[top_idx] <= vec;
    end
    rd_data <= mem[iss_idx];
  end

`ifndef SYNTH
  // rank always counts the occupied rows
  a_rank_matches_rows: assert property (@(posedge clk) disable iff (rst)
    $countones(row_vld) == int'(rank))
    else $error("rank does not match occupied row count");

  // an independent insert always leaves a nonzero rank
  a_indep_rank: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.independent) |-> (rsp.rank != '0))
    else $error("independent result with zero rank");

  // a result only appears out of the commit cycle
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_vld) |-> $past(state == xbi_pkg::S_DONE))
    else $error("result raised outside commit");

  // the walk ends right after row zero has been handled
  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == xbi_pkg::S_RUN && last) |=> (state == xbi_pkg::S_DONE))
    else $error("reduction walk did not end at row zero");
`endif

endmodule
